>>> rtl/core/tanv_pkg.sv
`timescale 1ns / 1ps

package tanv_pkg;

   localparam int CoordWidth   = 16;
   localparam int ThreshWidth  = 16;
   localparam int AreaWidth    = 33;
   localparam int VolumeWidth  = 47;
   localparam int NormalWidth  = 16;

   // one root bit per step, 68-bit radicand
   localparam int SqrtSteps    = 34;
   // quotient bits of the normalizing divide, magnitude at most 2^14
   localparam int DivSteps     = 15;
   // base-4 digits of the volume magnitude divided by three
   localparam int VolSteps     = 25;
   localparam int BackDepth    = SqrtSteps + DivSteps + 1;

   localparam int NormOne      = 16384;

   typedef struct packed {
      logic [67:0]       sq;
      logic [2:0][34:0]  n;
      logic              degen;
      logic [33:0]       root;
      logic [37:0]       rem;
      logic              vneg;
      logic [49:0]       vmag;
      logic [49:0]       vq;
      logic [1:0]        vr;
      logic [2:0][48:0]  d;
      logic [2:0][14:0]  q;
   } back_type;

endpackage

>>> rtl/core/triangle_area_normal_volume_core.sv
`timescale 1ns / 1ps

// Triangle area, unit normal and signed origin volume, fully pipelined.
// Input channel req_*: one triangle per item, three vertices in signed Q8.8.
// Result channel rsp_*: area (Q16.16), signed volume (Q24.24), normal (Q1.14)
// and the degenerate flag, one result item per input item, in order.
// csr_write_enable / csr_write_data set min_magnitude; write it only while idle.
// Throughput: one item per cycle when the receiver does not stall. The depth is
// set by the square root (34 stages, one root bit each) and the normalizing
// divide (15 stages, one quotient bit each, three lanes).
// The whole pipeline advances together: when the result waits in the output
// register and rsp_ready is low, every stage holds and req_ready drops, so
// nothing is lost or repeated. Empty stages travel as bubbles.
// Reset clears every valid bit and sets min_magnitude to 0; the pipeline is
// ready in the first cycle after reset.
module triangle_area_normal_volume_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [tanv_pkg::ThreshWidth-1:0]       csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [tanv_pkg::CoordWidth-1:0] req_a_x,
   input  logic signed [tanv_pkg::CoordWidth-1:0] req_a_y,
   input  logic signed [tanv_pkg::CoordWidth-1:0] req_a_z,
   input  logic signed [tanv_pkg::CoordWidth-1:0] req_b_x,
   input  logic signed [tanv_pkg::CoordWidth-1:0] req_b_y,
   input  logic signed [tanv_pkg::CoordWidth-1:0] req_b_z,
   input  logic signed [tanv_pkg::CoordWidth-1:0] req_c_x,
   input  logic signed [tanv_pkg::CoordWidth-1:0] req_c_y,
   input  logic signed [tanv_pkg::CoordWidth-1:0] req_c_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [tanv_pkg::AreaWidth-1:0]         rsp_area,
   output logic signed [tanv_pkg::VolumeWidth-1:0] rsp_signed_volume,
   output logic signed [tanv_pkg::NormalWidth-1:0] rsp_normal_x,
   output logic signed [tanv_pkg::NormalWidth-1:0] rsp_normal_y,
   output logic signed [tanv_pkg::NormalWidth-1:0] rsp_normal_z,
   output logic                                   rsp_degenerate
);
   import tanv_pkg::*;

   logic [ThreshWidth-1:0] min_magnitude_ff;
   logic [31:0]            thr2;
   logic                   en;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_magnitude_ff <= '0;
      end else if (csr_write_enable) begin
         min_magnitude_ff <= csr_write_data;
      end
   end

   assign thr2 = 32'(min_magnitude_ff) * 32'(min_magnitude_ff);

   // stage 1: input register
   logic s1_valid_ff;
   logic signed [15:0] s1_a_ff [0:2];
   logic signed [15:0] s1_b_ff [0:2];
   logic signed [15:0] s1_c_ff [0:2];

   // stage 2: edges and B x C partial products
   logic s2_valid_ff;
   logic signed [16:0] s2_v_ff [0:2];
   logic signed [16:0] s2_w_ff [0:2];
   logic signed [15:0] s2_a_ff [0:2];
   logic signed [31:0] s2_p_ff [0:5];

   // stage 3: edge cross partial products, B x C
   logic s3_valid_ff;
   logic signed [33:0] s3_x_ff  [0:5];
   logic signed [32:0] s3_bc_ff [0:2];
   logic signed [15:0] s3_a_ff  [0:2];

   // stage 4: normal, triple product terms
   logic s4_valid_ff;
   logic signed [34:0] s4_n_ff [0:2];
   logic signed [48:0] s4_t_ff [0:2];

   // stage 5: square partial products, volume sum
   logic s5_valid_ff;
   logic signed [34:0] s5_n_ff  [0:2];
   logic [33:0]        s5_hh_ff [0:2];
   logic [33:0]        s5_hl_ff [0:2];
   logic [33:0]        s5_ll_ff [0:2];
   logic signed [50:0] s5_vol_ff;

   // stage 6: squares, volume sign and magnitude
   logic s6_valid_ff;
   logic signed [34:0] s6_n_ff  [0:2];
   logic [67:0]        s6_sq_ff [0:2];
   logic               s6_vneg_ff;
   logic [50:0]        s6_vmag_ff;

   logic [33:0] s5_nabs [0:2];

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s5_nabs[i] = s4_n_ff[i][34] ? 34'(-s4_n_ff[i]) : 34'(s4_n_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_a_ff[0] <= req_a_x;
         s1_a_ff[1] <= req_a_y;
         s1_a_ff[2] <= req_a_z;
         s1_b_ff[0] <= req_b_x;
         s1_b_ff[1] <= req_b_y;
         s1_b_ff[2] <= req_b_z;
         s1_c_ff[0] <= req_c_x;
         s1_c_ff[1] <= req_c_y;
         s1_c_ff[2] <= req_c_z;

         for (int i = 0; i < 3; i++) begin
            s2_v_ff[i] <= 17'(s1_b_ff[i]) - 17'(s1_a_ff[i]);
            s2_w_ff[i] <= 17'(s1_c_ff[i]) - 17'(s1_a_ff[i]);
            s2_a_ff[i] <= s1_a_ff[i];
         end
         s2_p_ff[0] <= 32'(s1_b_ff[1]) * 32'(s1_c_ff[2]);
         s2_p_ff[1] <= 32'(s1_b_ff[2]) * 32'(s1_c_ff[1]);
         s2_p_ff[2] <= 32'(s1_b_ff[2]) * 32'(s1_c_ff[0]);
         s2_p_ff[3] <= 32'(s1_b_ff[0]) * 32'(s1_c_ff[2]);
         s2_p_ff[4] <= 32'(s1_b_ff[0]) * 32'(s1_c_ff[1]);
         s2_p_ff[5] <= 32'(s1_b_ff[1]) * 32'(s1_c_ff[0]);

         s3_x_ff[0] <= 34'(s2_v_ff[1]) * 34'(s2_w_ff[2]);
         s3_x_ff[1] <= 34'(s2_v_ff[2]) * 34'(s2_w_ff[1]);
         s3_x_ff[2] <= 34'(s2_v_ff[2]) * 34'(s2_w_ff[0]);
         s3_x_ff[3] <= 34'(s2_v_ff[0]) * 34'(s2_w_ff[2]);
         s3_x_ff[4] <= 34'(s2_v_ff[0]) * 34'(s2_w_ff[1]);
         s3_x_ff[5] <= 34'(s2_v_ff[1]) * 34'(s2_w_ff[0]);
         s3_bc_ff[0] <= 33'(s2_p_ff[0]) - 33'(s2_p_ff[1]);
         s3_bc_ff[1] <= 33'(s2_p_ff[2]) - 33'(s2_p_ff[3]);
         s3_bc_ff[2] <= 33'(s2_p_ff[4]) - 33'(s2_p_ff[5]);
         for (int i = 0; i < 3; i++) begin
            s3_a_ff[i] <= s2_a_ff[i];
         end

         for (int i = 0; i < 3; i++) begin
            s4_n_ff[i] <= 35'(s3_x_ff[2*i]) - 35'(s3_x_ff[2*i+1]);
            s4_t_ff[i] <= 49'(s3_a_ff[i]) * 49'(s3_bc_ff[i]);
         end

         for (int i = 0; i < 3; i++) begin
            s5_n_ff[i]  <= s4_n_ff[i];
            s5_hh_ff[i] <= 34'(s5_nabs[i][33:17]) * 34'(s5_nabs[i][33:17]);
            s5_hl_ff[i] <= 34'(s5_nabs[i][33:17]) * 34'(s5_nabs[i][16:0]);
            s5_ll_ff[i] <= 34'(s5_nabs[i][16:0]) * 34'(s5_nabs[i][16:0]);
         end
         s5_vol_ff <= 51'(s4_t_ff[0]) + 51'(s4_t_ff[1]) + 51'(s4_t_ff[2]);

         for (int i = 0; i < 3; i++) begin
            s6_n_ff[i]  <= s5_n_ff[i];
            s6_sq_ff[i] <= (68'(s5_hh_ff[i]) << 34) + (68'(s5_hl_ff[i]) << 18)
                           + 68'(s5_ll_ff[i]);
         end
         s6_vneg_ff <= s5_vol_ff[50];
         s6_vmag_ff <= s5_vol_ff[50] ? 51'(-s5_vol_ff) : 51'(s5_vol_ff);
      end
   end

   // back end: sum of squares, then square root, then divide; the volume is divided by three alongside the root
   back_type          back_ff [0:BackDepth-1];
   logic [BackDepth-1:0] back_valid_ff;
   back_type          entry_in;

   always_comb begin
      entry_in      = '0;
      entry_in.sq   = s6_sq_ff[0] + s6_sq_ff[1] + s6_sq_ff[2];
      for (int i = 0; i < 3; i++) begin
         entry_in.n[i] = s6_n_ff[i];
      end
      entry_in.vneg = s6_vneg_ff;
      // divide by two here, the steps below divide by three
      entry_in.vmag = s6_vmag_ff[50:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         back_valid_ff <= '0;
      end else if (en) begin
         back_valid_ff <= {back_valid_ff[BackDepth-2:0], s6_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         back_ff[0] <= entry_in;
      end
   end

   for (genvar j = 1; j < BackDepth; j++) begin : g_back
      localparam int K = j - 1;
      back_type back_in;

      if (j <= SqrtSteps) begin : g_sqrt
         logic [37:0] radix;
         logic [37:0] trial;
         logic [3:0]  vx;
         logic [34:0] nabs [0:2];

         always_comb begin
            back_in = back_ff[j-1];
            radix   = {back_ff[j-1].rem[35:0], back_ff[j-1].sq[67:66]};
            trial   = {2'b00, back_ff[j-1].root, 2'b01};
            back_in.sq = {back_ff[j-1].sq[65:0], 2'b00};
            if (radix >= trial) begin
               back_in.rem  = radix - trial;
               back_in.root = {back_ff[j-1].root[32:0], 1'b1};
            end else begin
               back_in.rem  = radix;
               back_in.root = {back_ff[j-1].root[32:0], 1'b0};
            end

            if (K == 0) begin
               back_in.degen = (back_ff[j-1].sq <= 68'(thr2));
            end

            // volume magnitude divided by three, one base-4 digit per step
            vx = {back_ff[j-1].vr, back_ff[j-1].vmag[49:48]};
            if (K < VolSteps) begin
               back_in.vmag = {back_ff[j-1].vmag[47:0], 2'b00};
               if (vx >= 4'd9) begin
                  back_in.vq = {back_ff[j-1].vq[47:0], 2'd3};
                  back_in.vr = 2'(vx - 4'd9);
               end else if (vx >= 4'd6) begin
                  back_in.vq = {back_ff[j-1].vq[47:0], 2'd2};
                  back_in.vr = 2'(vx - 4'd6);
               end else if (vx >= 4'd3) begin
                  back_in.vq = {back_ff[j-1].vq[47:0], 2'd1};
                  back_in.vr = 2'(vx - 4'd3);
               end else begin
                  back_in.vq = {back_ff[j-1].vq[47:0], 2'd0};
                  back_in.vr = vx[1:0];
               end
            end

            // load the dividends for the normalizing divide
            for (int i = 0; i < 3; i++) begin
               nabs[i] = back_ff[j-1].n[i][34] ? (~back_ff[j-1].n[i] + 35'd1)
                                               : back_ff[j-1].n[i];
            end
            if (K == SqrtSteps - 1) begin
               for (int i = 0; i < 3; i++) begin
                  back_in.d[i] = {1'b0, nabs[i][33:0], 14'd0};
                  back_in.q[i] = '0;
               end
            end
         end
      end else begin : g_div
         localparam int B = DivSteps - 1 - (j - 1 - SqrtSteps);
         logic [48:0] trial;

         always_comb begin
            back_in = back_ff[j-1];
            trial   = 49'(back_ff[j-1].root) << B;
            for (int i = 0; i < 3; i++) begin
               if (back_ff[j-1].d[i] >= trial) begin
                  back_in.d[i]    = back_ff[j-1].d[i] - trial;
                  back_in.q[i][B] = 1'b1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            back_ff[j] <= back_in;
         end
      end
   end

   // output stage
   back_type                    last;
   logic signed [34:0]          shifted [0:2];
   logic signed [NormalWidth-1:0] normal_in [0:2];
   logic [AreaWidth-1:0]        area_in;
   logic signed [VolumeWidth-1:0] volume_in;

   logic                         rsp_valid_ff;
   logic [AreaWidth-1:0]         rsp_area_ff;
   logic signed [VolumeWidth-1:0] rsp_volume_ff;
   logic signed [NormalWidth-1:0] rsp_normal_ff [0:2];
   logic                         rsp_degenerate_ff;

   assign last = back_ff[BackDepth-1];

   always_comb begin
      area_in   = last.root[33:1];
      volume_in = last.vneg ? -47'(last.vq) : 47'(last.vq);
      for (int i = 0; i < 3; i++) begin
         shifted[i] = $signed(last.n[i]) >>> 2;
         if (last.degen) begin
            if (shifted[i] > 35'sd16384) begin
               normal_in[i] = 16'(NormOne);
            end else if (shifted[i] < -35'sd16384) begin
               normal_in[i] = -16'(NormOne);
            end else begin
               normal_in[i] = shifted[i][15:0];
            end
         end else begin
            normal_in[i] = last.n[i][34] ? -{1'b0, last.q[i]} : {1'b0, last.q[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= back_valid_ff[BackDepth-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_area_ff       <= area_in;
         rsp_volume_ff     <= volume_in;
         rsp_degenerate_ff <= last.degen;
         for (int i = 0; i < 3; i++) begin
            rsp_normal_ff[i] <= normal_in[i];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_area          = rsp_area_ff;
   assign rsp_signed_volume = rsp_volume_ff;
   assign rsp_normal_x      = rsp_normal_ff[0];
   assign rsp_normal_y      = rsp_normal_ff[1];
   assign rsp_normal_z      = rsp_normal_ff[2];
   assign rsp_degenerate    = rsp_degenerate_ff;

   // root remainder never exceeds twice the root
   a_sqrt_rem : assert property (@(posedge clock) disable iff (reset)
      back_valid_ff[SqrtSteps] |->
         back_ff[SqrtSteps].rem <= {3'b000, back_ff[SqrtSteps].root, 1'b0})
      else $error("square root remainder out of range");

   a_vol_rem : assert property (@(posedge clock) disable iff (reset)
      back_valid_ff[VolSteps] |-> back_ff[VolSteps].vr < 2'd3)
      else $error("volume remainder not below three");

   a_div_root : assert property (@(posedge clock) disable iff (reset)
      back_valid_ff[BackDepth-1] && !back_ff[BackDepth-1].degen |->
         back_ff[BackDepth-1].root != '0)
      else $error("normalizing by a zero root");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(back_valid_ff))
      else $error("pipeline moved while stalled");

   a_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
